### src/m68020_effective_address_macros.svh
// Assertion macros shared by the effective address checker.
// Sampled on clk_i and held off while rst_ni is low.
`ifndef M68020_EFFECTIVE_ADDRESS_MACROS_SVH
`define M68020_EFFECTIVE_ADDRESS_MACROS_SVH

// Plain clocked property with reset disable.
`define M68EA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must hold whenever a result is on the output channel.
`define M68EA_ASSERT_VALID(label, cond, msg) \
  `M68EA_ASSERT(label, out_valid_o |-> (cond), msg)

`endif

### src/m68ea_pkg.sv
// Shared types and codes for the 68020 effective address unit.
// No dependencies; imported by every module of the block.
package m68ea_pkg;

  typedef enum logic [1:0] {
    KIND_DONE    = 2'd0,
    KIND_READ    = 2'd1,
    KIND_ILLEGAL = 2'd2
  } kind_e;

  localparam logic OP_START    = 1'b0;
  localparam logic OP_READ_RSP = 1'b1;

  localparam logic [2:0] MODE_AIND    = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_DISP    = 3'd5;
  localparam logic [2:0] MODE_INDEX   = 3'd6;
  localparam logic [2:0] MODE_SPECIAL = 3'd7;

  localparam logic [2:0] REG_ABS_W    = 3'd0;
  localparam logic [2:0] REG_ABS_L    = 3'd1;
  localparam logic [2:0] REG_PC_DISP  = 3'd2;
  localparam logic [2:0] REG_PC_INDEX = 3'd3;
  localparam logic [2:0] REG_A7       = 3'd7;

  // full extension word displacement size codes
  localparam logic [1:0] DSZ_RESERVED = 2'd0;
  localparam logic [1:0] DSZ_NULL     = 2'd1;

  localparam logic [2:0] SIZE_NONE = 3'd0;
  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_WORD = 3'd2;

  typedef struct packed {
    logic        op;
    logic [2:0]  mode;
    logic [2:0]  reg_num;
    logic [2:0]  size_bytes;
    logic        is_write;
    logic [31:0] areg_value;
    logic [31:0] index_value;
    logic [31:0] pc_value;
    logic [15:0] ext_word;
    logic [31:0] displacement;
    logic [31:0] outer_disp;
    logic [31:0] read_data;
  } ea_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic        areg_write;
    logic [31:0] new_areg;
  } ea_result_t;

  typedef struct packed {
    logic        pending;
    logic        pending_post;
    logic [31:0] saved_index;
    logic [31:0] saved_outer;
  } ea_state_t;

endpackage

### src/m68020_effective_address.sv
// 68020 effective address unit: input register, calculation, output register.
// The result is computed from the input register and captured in the output register,
// from which it transfers out. Throughput: one item per cycle while the output is not
// stalled; input and output registers each pass one item per edge.
// A read response with nothing pending is consumed and gives no result.
// Reset clears both valid flags and the pending indirection state.
module m68020_effective_address (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [2:0]         mode_i,
  input  logic [2:0]         reg_num_i,
  input  logic [2:0]         size_bytes_i,
  input  logic               is_write_i,
  input  logic [31:0]        areg_value_i,
  input  logic [31:0]        index_value_i,
  input  logic [31:0]        pc_value_i,
  input  logic [15:0]        ext_word_i,
  input  logic signed [31:0] displacement_i,
  input  logic signed [31:0] outer_disp_i,
  input  logic [31:0]        read_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [31:0]        address_o,
  output logic               areg_write_o,
  output logic [31:0]        new_areg_o
);
  import m68ea_pkg::*;

  ea_item_t   item_q;
  logic       item_valid_q, item_valid_d;
  ea_state_t  state_q, state_d, calc_state;
  ea_result_t calc_result, out_result;
  logic       has_result, out_ready, item_go, in_xfer;

  // advance when the output can take the result, or there is none to give
  assign item_go    = item_valid_q && (out_ready || !has_result);
  assign in_stall_o = item_valid_q && !item_go;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_xfer) begin
      item_valid_d = 1'b1;
    end else if (item_go) begin
      item_valid_d = 1'b0;
    end
    state_d = item_go ? calc_state : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      state_q      <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      state_q      <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= '{op: op_i, mode: mode_i, reg_num: reg_num_i, size_bytes: size_bytes_i,
                  is_write: is_write_i, areg_value: areg_value_i,
                  index_value: index_value_i, pc_value: pc_value_i,
                  ext_word: ext_word_i, displacement: displacement_i,
                  outer_disp: outer_disp_i, read_data: read_data_i};
    end
  end

  m68ea_calc u_calc (
    .item_i      (item_q),
    .state_i     (state_q),
    .result_o    (calc_result),
    .has_result_o(has_result),
    .state_o     (calc_state)
  );

  m68ea_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (item_valid_q && has_result),
    .result_i(calc_result),
    .stall_i (out_stall_i),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .result_o(out_result)
  );

  assign kind_o       = out_result.kind;
  assign address_o    = out_result.address;
  assign areg_write_o = out_result.areg_write;
  assign new_areg_o   = out_result.new_areg;

endmodule

### src/m68ea_calc.sv
// Combinational address calculation for one registered item.
// Depends on m68ea_pkg; produces the result and the next indirection state.
module m68ea_calc (
  input  m68ea_pkg::ea_item_t   item_i,
  input  m68ea_pkg::ea_state_t  state_i,
  output m68ea_pkg::ea_result_t result_o,
  output logic                  has_result_o,
  output m68ea_pkg::ea_state_t  state_o
);
  import m68ea_pkg::*;

  logic [15:0] ext;
  logic [31:0] base_raw, idx_w, sidx, d8, bd, od, base_f, sidx_f;
  logic [1:0]  bdc, odc;
  logic        post, isup, bsup;
  logic [2:0]  step;
  logic [31:0] step_w;

  ea_result_t  xres;
  ea_state_t   xstate;

  assign ext      = item_i.ext_word;
  assign base_raw = (item_i.mode == MODE_INDEX) ? item_i.areg_value : item_i.pc_value;
  assign idx_w    = ext[11] ? item_i.index_value
                            : {{16{item_i.index_value[15]}}, item_i.index_value[15:0]};
  assign sidx     = idx_w << ext[10:9];
  assign d8       = {{24{ext[7]}}, ext[7:0]};
  assign bdc      = ext[5:4];
  assign odc      = ext[1:0];
  assign post     = ext[2];
  assign isup     = ext[6];
  assign bsup     = ext[7];
  assign bd       = (bdc == DSZ_NULL) ? 32'd0 : item_i.displacement;
  assign od       = (odc == DSZ_NULL) ? 32'd0 : item_i.outer_disp;
  assign base_f   = bsup ? 32'd0 : base_raw;
  assign sidx_f   = isup ? 32'd0 : sidx;

  // A7 stays word aligned for byte operands
  assign step   = (item_i.reg_num == REG_A7 && item_i.size_bytes == SIZE_BYTE)
                  ? SIZE_WORD : item_i.size_bytes;
  assign step_w = {29'd0, step};

  // indexed forms, brief and full
  always_comb begin
    xres   = '{kind: KIND_ILLEGAL, address: 32'd0, areg_write: 1'b0, new_areg: 32'd0};
    xstate = '0;
    if (!ext[8]) begin
      xres.kind    = KIND_DONE;
      xres.address = base_raw + sidx + d8;
    end else if (ext[3] || bdc == DSZ_RESERVED || (isup && post)
                 || (odc == DSZ_RESERVED && post)) begin
      xres.kind = KIND_ILLEGAL;
    end else if (odc == DSZ_RESERVED) begin
      xres.kind    = KIND_DONE;
      xres.address = base_f + sidx_f + bd;
    end else begin
      xres.kind           = KIND_READ;
      xres.address        = base_f + (post ? 32'd0 : sidx_f) + bd;
      xstate.pending      = 1'b1;
      xstate.pending_post = post;
      xstate.saved_index  = post ? sidx_f : 32'd0;
      xstate.saved_outer  = od;
    end
  end

  always_comb begin
    result_o     = '{kind: KIND_ILLEGAL, address: 32'd0, areg_write: 1'b0, new_areg: 32'd0};
    has_result_o = 1'b1;
    state_o      = '0;
    if (item_i.op == OP_READ_RSP) begin
      if (!state_i.pending) begin
        has_result_o = 1'b0;
        state_o      = state_i;
      end else begin
        result_o.kind    = KIND_DONE;
        result_o.address = item_i.read_data
                           + (state_i.pending_post ? state_i.saved_index : 32'd0)
                           + state_i.saved_outer;
      end
    end else begin
      case (item_i.mode)
        MODE_AIND: begin
          result_o.kind    = KIND_DONE;
          result_o.address = item_i.areg_value;
        end
        MODE_POSTINC: begin
          if (item_i.size_bytes != SIZE_NONE) begin
            result_o.kind       = KIND_DONE;
            result_o.address    = item_i.areg_value;
            result_o.areg_write = 1'b1;
            result_o.new_areg   = item_i.areg_value + step_w;
          end
        end
        MODE_PREDEC: begin
          if (item_i.size_bytes != SIZE_NONE) begin
            result_o.kind       = KIND_DONE;
            result_o.address    = item_i.areg_value - step_w;
            result_o.areg_write = 1'b1;
            result_o.new_areg   = item_i.areg_value - step_w;
          end
        end
        MODE_DISP: begin
          result_o.kind    = KIND_DONE;
          result_o.address = item_i.areg_value + item_i.displacement;
        end
        MODE_INDEX: begin
          result_o = xres;
          state_o  = xstate;
        end
        MODE_SPECIAL: begin
          case (item_i.reg_num)
            REG_ABS_W, REG_ABS_L: begin
              result_o.kind    = KIND_DONE;
              result_o.address = item_i.displacement;
            end
            REG_PC_DISP: begin
              if (!item_i.is_write) begin
                result_o.kind    = KIND_DONE;
                result_o.address = item_i.pc_value + item_i.displacement;
              end
            end
            REG_PC_INDEX: begin
              if (!item_i.is_write) begin
                result_o = xres;
                state_o  = xstate;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      // illegal results never leave an indirection behind
      if (result_o.kind == KIND_ILLEGAL) begin
        state_o = '0;
      end
    end
  end

endmodule

### src/m68ea_out_reg.sv
// Output register of the address unit: holds one result until transfer.
// Depends on m68ea_pkg for the result type.
module m68ea_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  m68ea_pkg::ea_result_t result_i,
  input  logic                  stall_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output m68ea_pkg::ea_result_t result_o
);
  import m68ea_pkg::*;

  logic       valid_q, valid_d;
  ea_result_t result_q;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### src/m68ea_checker.sv
// Port-level checks for the effective address unit, bound to the top level.
// Depends on m68ea_pkg and the macro header.
`include "m68020_effective_address_macros.svh"

module m68ea_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         kind_o,
  input logic [31:0]        address_o,
  input logic               areg_write_o,
  input logic [31:0]        new_areg_o
);
  import m68ea_pkg::*;

  // a stalled result keeps its place and its address
  `M68EA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(address_o), "stalled result changed")
  `M68EA_ASSERT_VALID(a_illegal_zero, kind_o != KIND_ILLEGAL || (address_o == 32'd0 && !areg_write_o), "illegal result carries an address")
  `M68EA_ASSERT_VALID(a_wb_done, !areg_write_o || kind_o == KIND_DONE, "register update on a non-final result")
  `M68EA_ASSERT_VALID(a_new_areg_zero, areg_write_o || new_areg_o == 32'd0, "new_areg set without update")

endmodule

bind m68020_effective_address m68ea_checker u_m68ea_checker (.*);

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for m68020_effective_address: a queue-fed driver, a
// result monitor and an in-bench address predictor. Depends on m68ea_pkg and the unit.
module testbench;
  import m68ea_pkg::*;

  localparam logic [2:0] MODE_DREG = 3'd0;
  localparam logic [2:0] MODE_AREG = 3'd1;
  localparam logic [2:0] REG_IMM   = 3'd4;
  localparam logic [2:0] SIZE_LONG = 3'd4;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int HOLD_CYCLES      = 250;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 10;

  logic clk_i;
  logic rst_ni;

  ea_item_t   in_item   = '0;
  logic       in_valid  = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [31:0] address_o;
  logic       areg_write_o;
  logic [31:0] new_areg_o;

  ea_item_t   stim_q[$];
  ea_result_t addr_expect_q[$];

  // predictor copy of the indirection state
  logic        ind_pending = 1'b0;
  logic        ind_post    = 1'b0;
  logic [31:0] ind_index   = '0;
  logic [31:0] ind_outer   = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_off     = 1'b0;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_in       = 0;
  int unsigned ignored_rsp    = 0;
  int unsigned results_seen   = 0;
  int unsigned done_seen      = 0;
  int unsigned read_seen      = 0;
  int unsigned illegal_seen   = 0;

  m68020_effective_address dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .op_i          (in_item.op),
    .mode_i        (in_item.mode),
    .reg_num_i     (in_item.reg_num),
    .size_bytes_i  (in_item.size_bytes),
    .is_write_i    (in_item.is_write),
    .areg_value_i  (in_item.areg_value),
    .index_value_i (in_item.index_value),
    .pc_value_i    (in_item.pc_value),
    .ext_word_i    (in_item.ext_word),
    .displacement_i(in_item.displacement),
    .outer_disp_i  (in_item.outer_disp),
    .read_data_i   (in_item.read_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .kind_o        (kind_o),
    .address_o     (address_o),
    .areg_write_o  (areg_write_o),
    .new_areg_o    (new_areg_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic ea_item_t make_start(input logic [2:0] mode, input logic [2:0] rn,
                                          input logic [2:0] size, input logic wr,
                                          input logic [15:0] ext);
    ea_item_t it;
    it.op           = OP_START;
    it.mode         = mode;
    it.reg_num      = rn;
    it.size_bytes   = size;
    it.is_write     = wr;
    it.areg_value   = $urandom;
    it.index_value  = $urandom;
    it.pc_value     = $urandom;
    it.ext_word     = ext;
    it.displacement = $urandom;
    it.outer_disp   = $urandom;
    it.read_data    = $urandom;
    return it;
  endfunction

  function automatic ea_item_t make_rsp();
    ea_item_t it;
    it    = make_start(3'($urandom), 3'($urandom), 3'($urandom), 1'($urandom),
                       16'($urandom));
    it.op = OP_READ_RSP;
    return it;
  endfunction

  // Indexed forms; ext bit 8 picks full format, bits 5:4 / 1:0 size the
  // base and outer displacements, bit 2 selects post-indexing.
  function automatic void calc_indexed(input ea_item_t it, input logic [31:0] base_in,
                                       inout ea_result_t res);
    logic [15:0] ext;
    logic [31:0] base, idx, sidx, bd, od;
    ext  = it.ext_word;
    base = base_in;
    idx  = it.index_value;
    if (!ext[11]) idx = {{16{idx[15]}}, idx[15:0]};
    sidx = idx << ext[10:9];
    if (!ext[8]) begin
      res.address = base + sidx + {{24{ext[7]}}, ext[7:0]};
      return;
    end
    if (ext[3] || ext[5:4] == DSZ_RESERVED || (ext[6] && ext[2]) ||
        (ext[1:0] == DSZ_RESERVED && ext[2])) begin
      res.kind = KIND_ILLEGAL;
      return;
    end
    bd = (ext[5:4] == DSZ_NULL) ? 32'd0 : it.displacement;
    od = (ext[1:0] == DSZ_NULL) ? 32'd0 : it.outer_disp;
    if (ext[7]) base = '0;
    if (ext[6]) sidx = '0;
    if (ext[1:0] == DSZ_RESERVED) begin
      res.address = base + sidx + bd;
      return;
    end
    ind_pending = 1'b1;
    ind_post    = ext[2];
    ind_outer   = od;
    res.kind    = KIND_READ;
    if (ext[2]) begin
      ind_index   = sidx;
      res.address = base + bd;
    end else begin
      ind_index   = '0;
      res.address = base + sidx + bd;
    end
  endfunction

  // Returns 1 when the item produces a result.
  function automatic bit calc_effective_address(input ea_item_t it, output ea_result_t res);
    logic [31:0] step, na;
    res.kind       = KIND_DONE;
    res.address    = '0;
    res.areg_write = 1'b0;
    res.new_areg   = '0;
    if (it.op == OP_READ_RSP) begin
      if (!ind_pending) return 1'b0;
      res.address = it.read_data + (ind_post ? ind_index : 32'd0) + ind_outer;
      ind_pending = 1'b0;
      ind_post    = 1'b0;
      ind_index   = '0;
      ind_outer   = '0;
      return 1'b1;
    end
    // any start drops an outstanding indirection
    ind_pending = 1'b0;
    ind_post    = 1'b0;
    ind_index   = '0;
    ind_outer   = '0;
    step = {29'd0, it.size_bytes};
    if (it.reg_num == REG_A7 && it.size_bytes == SIZE_BYTE) step = {29'd0, SIZE_WORD};
    case (it.mode)
      MODE_AIND: res.address = it.areg_value;
      MODE_POSTINC: begin
        if (it.size_bytes == SIZE_NONE) begin
          res.kind = KIND_ILLEGAL;
        end else begin
          res.address    = it.areg_value;
          res.areg_write = 1'b1;
          res.new_areg   = it.areg_value + step;
        end
      end
      MODE_PREDEC: begin
        if (it.size_bytes == SIZE_NONE) begin
          res.kind = KIND_ILLEGAL;
        end else begin
          na             = it.areg_value - step;
          res.address    = na;
          res.areg_write = 1'b1;
          res.new_areg   = na;
        end
      end
      MODE_DISP:  res.address = it.areg_value + it.displacement;
      MODE_INDEX: calc_indexed(it, it.areg_value, res);
      MODE_SPECIAL: begin
        case (it.reg_num)
          REG_ABS_W, REG_ABS_L: res.address = it.displacement;
          REG_PC_DISP: begin
            if (it.is_write) res.kind = KIND_ILLEGAL;
            else res.address = it.pc_value + it.displacement;
          end
          REG_PC_INDEX: begin
            if (it.is_write) res.kind = KIND_ILLEGAL;
            else calc_indexed(it, it.pc_value, res);
          end
          default: res.kind = KIND_ILLEGAL;
        endcase
      end
      default: res.kind = KIND_ILLEGAL;
    endcase
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 50)
      $display("%0t ns: %s mismatch, got %h want %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // driver: predict on each transfer, then offer the next item or idle
  always @(posedge clk_i) begin
    ea_result_t want;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        items_in++;
        if (calc_effective_address(in_item, want)) addr_expect_q.push_back(want);
        else ignored_rsp++;
        void'(stim_q.pop_front());
      end
      if (!(in_valid && in_stall_o)) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= stim_q[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    ea_result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (addr_expect_q.size() == 0) begin
          report_mismatch("unexpected result, address", address_o, 32'd0);
        end else begin
          want = addr_expect_q.pop_front();
          case (want.kind)
            KIND_DONE: done_seen++;
            KIND_READ: read_seen++;
            default:   illegal_seen++;
          endcase
          if (kind_o !== want.kind) report_mismatch("kind", 32'(kind_o), 32'(want.kind));
          if (address_o !== want.address) report_mismatch("address", address_o, want.address);
          if (areg_write_o !== want.areg_write)
            report_mismatch("areg_write", 32'(areg_write_o), 32'(want.areg_write));
          if (new_areg_o !== want.new_areg) report_mismatch("new_areg", new_areg_o, want.new_areg);
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", addr_expect_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // long output hold-off early in the first phase so the pipeline backs up
  initial begin
    wait (rst_ni);
    repeat (30) @(negedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    ea_item_t it;
    logic [15:0] ext;
    int n;
    int pick;
    wait (rst_ni);
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk_i);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (ph == 0) begin
        stim_q.push_back(make_start(MODE_DREG, 3'd3, SIZE_WORD, 1'b0, 16'h0000));
        stim_q.push_back(make_start(MODE_AREG, 3'd5, SIZE_LONG, 1'b1, 16'h0000));
        it = make_start(MODE_AIND, 3'd0, SIZE_LONG, 1'b0, 16'h0000);
        it.areg_value = '1;
        stim_q.push_back(it);
        stim_q.push_back(make_start(MODE_POSTINC, 3'd1, SIZE_NONE, 1'b0, 16'h0000));
        it = make_start(MODE_POSTINC, REG_A7, SIZE_BYTE, 1'b1, 16'h0000);
        it.areg_value = '1;
        stim_q.push_back(it);
        it = make_start(MODE_PREDEC, REG_A7, SIZE_BYTE, 1'b0, 16'h0000);
        it.areg_value = '0;
        stim_q.push_back(it);
        stim_q.push_back(make_start(MODE_PREDEC, 3'd0, 3'd7, 1'b0, 16'h0000));
        it = make_start(MODE_DISP, 3'd2, SIZE_WORD, 1'b0, 16'h0000);
        it.areg_value   = '0;
        it.displacement = 32'h8000_0000;
        stim_q.push_back(it);
        // brief format, negative word index scaled by 8, most negative d8
        it = make_start(MODE_INDEX, 3'd4, SIZE_WORD, 1'b0, 16'hf680);
        it.index_value = 32'h0001_8000;
        stim_q.push_back(it);
        it = make_start(MODE_SPECIAL, REG_ABS_W, SIZE_WORD, 1'b1, 16'h0000);
        it.displacement = 32'hffff_8000;
        stim_q.push_back(it);
        it = make_start(MODE_SPECIAL, REG_ABS_L, SIZE_LONG, 1'b0, 16'h0000);
        it.displacement = '1;
        stim_q.push_back(it);
        stim_q.push_back(make_start(MODE_SPECIAL, REG_PC_DISP, SIZE_WORD, 1'b1, 16'h0000));
        stim_q.push_back(make_start(MODE_SPECIAL, REG_PC_DISP, SIZE_WORD, 1'b0, 16'h0000));
        stim_q.push_back(make_start(MODE_SPECIAL, REG_PC_INDEX, SIZE_WORD, 1'b1, 16'h087f));
        stim_q.push_back(make_start(MODE_SPECIAL, REG_PC_INDEX, SIZE_WORD, 1'b0, 16'h087f));
        stim_q.push_back(make_start(MODE_SPECIAL, REG_IMM, SIZE_WORD, 1'b0, 16'h0000));
        stim_q.push_back(make_start(MODE_SPECIAL, REG_A7, SIZE_WORD, 1'b0, 16'h0000));
        // full format: reserved bit 3, reserved base size, reserved I/IS combos
        stim_q.push_back(make_start(MODE_INDEX, 3'd0, SIZE_WORD, 1'b0, 16'h0118));
        stim_q.push_back(make_start(MODE_INDEX, 3'd0, SIZE_WORD, 1'b0, 16'h0101));
        stim_q.push_back(make_start(MODE_INDEX, 3'd0, SIZE_WORD, 1'b0, 16'h0156));
        stim_q.push_back(make_start(MODE_INDEX, 3'd0, SIZE_WORD, 1'b0, 16'h0114));
        // both suppressed, null base displacement, no memory indirection
        stim_q.push_back(make_start(MODE_INDEX, 3'd6, SIZE_WORD, 1'b0, 16'h01d0));
        // pre-indexed indirect with null outer, then post-indexed on the PC
        stim_q.push_back(make_start(MODE_INDEX, 3'd1, SIZE_LONG, 1'b0, 16'h0131));
        stim_q.push_back(make_rsp());
        stim_q.push_back(make_start(MODE_SPECIAL, REG_PC_INDEX, SIZE_LONG, 1'b0, 16'h0926));
        stim_q.push_back(make_rsp());
        // response with nothing outstanding, and a start that drops an indirection
        stim_q.push_back(make_rsp());
        stim_q.push_back(make_start(MODE_INDEX, 3'd2, SIZE_LONG, 1'b0, 16'h0122));
        stim_q.push_back(make_start(MODE_AIND, 3'd2, SIZE_LONG, 1'b0, 16'h0000));
        stim_q.push_back(make_rsp());
      end
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          // well-formed memory indirection, usually answered
          ext = 16'($urandom);
          ext[8]   = 1'b1;
          ext[3]   = 1'b0;
          ext[5:4] = 2'($urandom_range(3, 1));
          ext[1:0] = 2'($urandom_range(3, 1));
          if (ext[6]) ext[2] = 1'b0;
          if ($urandom_range(1))
            it = make_start(MODE_INDEX, 3'($urandom), 3'($urandom), 1'($urandom), ext);
          else it = make_start(MODE_SPECIAL, REG_PC_INDEX, 3'($urandom), 1'b0, ext);
          stim_q.push_back(it);
          n++;
          if ($urandom_range(99) < 85) begin
            stim_q.push_back(make_rsp());
            n++;
          end
        end else if (pick < 55) begin
          // indexed with arbitrary control bits, full or brief
          ext = 16'($urandom);
          ext[8] = (pick < 42);
          if ($urandom_range(1))
            it = make_start(MODE_INDEX, 3'($urandom), 3'($urandom), 1'($urandom), ext);
          else it = make_start(MODE_SPECIAL, REG_PC_INDEX, 3'($urandom), 1'($urandom), ext);
          stim_q.push_back(it);
          n++;
        end else if (pick < 95) begin
          stim_q.push_back(make_start(3'($urandom), 3'($urandom), 3'($urandom),
                                      1'($urandom), 16'($urandom)));
          n++;
        end else begin
          // stray response, usually ignored
          stim_q.push_back(make_rsp());
        end
      end
      wait (stim_q.size() == 0 && addr_expect_q.size() == 0);
    end
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items over four idle/stall phases, %0d stray responses dropped.",
             items_in, ignored_rsp);
    $display("Checked %0d results: %0d addresses, %0d read requests, %0d illegal.",
             results_seen, done_seen, read_seen, illegal_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
